>>> hdl/pcht_pkg.sv
// Shared types and constants for the PCI type 0 config header target.
// No dependencies; pci_config_header_target.sv and pcht_access.sv refer to this package.
`default_nettype none

package pcht_pkg;

    // Size of the configuration space in bytes (64 .. 4096)
    localparam int SPACE_BYTES = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Accesses past this end address read all-ones
    localparam logic [12:0] SPACE_LIM = 13'(SPACE_BYTES);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VENDOR         = 3'd0,
        CFG_DEVICE         = 3'd1,
        CFG_REVISION_ID    = 3'd2,
        CFG_CLASS_PROG_IF  = 3'd3,
        CFG_CLASS_SUBCLASS = 3'd4,
        CFG_BASE_CLASS     = 3'd5,
        CFG_SSVID          = 3'd6,
        CFG_SSDID          = 3'd7
    } t_cfg_idx;

    // Legal access sizes in bytes
    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_HALF = 3'd2;
    localparam logic [2:0] SIZE_WORD = 3'd4;

    // Byte offsets inside the 64-byte header
    localparam logic [5:0] OFF_VENDOR_LO    = 6'h00;
    localparam logic [5:0] OFF_VENDOR_HI    = 6'h01;
    localparam logic [5:0] OFF_DEVICE_LO    = 6'h02;
    localparam logic [5:0] OFF_DEVICE_HI    = 6'h03;
    localparam logic [5:0] OFF_COMMAND_LO   = 6'h04;
    localparam logic [5:0] OFF_COMMAND_HI   = 6'h05;
    localparam logic [5:0] OFF_REVISION     = 6'h08;
    localparam logic [5:0] OFF_PROG_IF      = 6'h09;
    localparam logic [5:0] OFF_SUBCLASS     = 6'h0a;
    localparam logic [5:0] OFF_BASE_CLASS   = 6'h0b;
    localparam logic [5:0] OFF_CACHE_LINE   = 6'h0c;
    localparam logic [5:0] OFF_LATENCY      = 6'h0d;
    localparam logic [5:0] OFF_SSVID_LO     = 6'h2c;
    localparam logic [5:0] OFF_SSVID_HI     = 6'h2d;
    localparam logic [5:0] OFF_SSDID_LO     = 6'h2e;
    localparam logic [5:0] OFF_SSDID_HI     = 6'h2f;
    localparam logic [5:0] OFF_INT_LINE     = 6'h3c;

    // One access word
    typedef struct packed {
        logic        cmd;
        logic [11:0] byte_offset;
        logic [2:0]  access_size;
        logic [31:0] write_data;
    } t_req;

    // Header contents: identification registers plus writable state
    typedef struct packed {
        logic [15:0] vendor_id;
        logic [15:0] device_id;
        logic [7:0]  revision_id;
        logic [7:0]  class_prog_if;
        logic [7:0]  class_subclass;
        logic [7:0]  base_class;
        logic [15:0] subsystem_vendor;
        logic [15:0] subsystem_device;
        logic [15:0] command_word;
        logic [7:0]  cache_line_size;
        logic [7:0]  latency_timer;
        logic [7:0]  interrupt_line;
    } t_hdr;

    // Byte updates to the writable header fields
    typedef struct packed {
        logic       cmd_lo_we;
        logic       cmd_hi_we;
        logic       cache_we;
        logic       lat_we;
        logic       int_we;
        logic [7:0] cmd_lo;
        logic [7:0] cmd_hi;
        logic [7:0] cache;
        logic [7:0] lat;
        logic [7:0] intl;
    } t_hdr_wr;

endpackage

`default_nettype wire

>>> hdl/pcht_if.sv
// Valid/ready channel interfaces for access words and read-data words.
// Depends on nothing; used by the top level pci_config_header_target.
`default_nettype none

interface pcht_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [11:0] byte_offset;
    logic [2:0]  access_size;
    logic [31:0] write_data;

    modport source (output valid, cmd, byte_offset, access_size, write_data,
                    input ready);
    modport sink   (input valid, cmd, byte_offset, access_size, write_data,
                    output ready);
endinterface

interface pcht_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

>>> hdl/pci_config_header_target.sv
// Top level of the PCI type 0 configuration header target.
// Depends on pcht_pkg, pcht_req_if / pcht_rsp_if and pcht_access.
//
// Usage
//   i_req  : access words (cmd, byte_offset, access_size, write_data),
//            valid/ready, taken on an edge with valid and ready both high.
//   o_rsp  : one read_data word per access word, in order, valid/ready.
//   i_cfg_*: identification register writes (vendor, device, revision,
//            class bytes, subsystem ids), index = register number, no
//            handshake; write only while no access is in flight.
//   Path:  a word taken into the input register moves on to the output
//            register and is offered on o_rsp once that register is free.
//   Throughput: one word per cycle while o_rsp is not held off; a word is
//            decoded in one pass of byte-lane logic between the input
//            register and the output register, and writes land in the
//            header in that same cycle, so the next word already sees them.
//   Stall: while o_rsp is held off, the finished word waits in the output
//            register and one more word can sit in the input register;
//            i_req.ready drops only when both are full.
//   Reset: synchronous, active low; clears both valid flags, the ID
//            registers and the writable bytes (command, cache line,
//            latency timer, interrupt line).
`default_nettype none

module pci_config_header_target (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcht_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pcht_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    pcht_req_if.sink                            i_req,
    pcht_rsp_if.source                          o_rsp
);

    // input stage
    logic            r_in_valid;
    pcht_pkg::t_req  r_req;
    // output stage
    logic            r_out_valid;
    logic [31:0]     r_rdata;
    // header contents
    pcht_pkg::t_hdr  r_hdr;
    pcht_pkg::t_hdr  n_hdr;

    logic              advance;
    logic [31:0]       acc_rdata;
    pcht_pkg::t_hdr_wr acc_wr;

    // input word moves to the output register when that slot is free
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_rdata;

    pcht_access u_access (
        .i_req       (r_req),
        .i_hdr       (r_hdr),
        .o_read_data (acc_rdata),
        .o_wr        (acc_wr)
    );

    always_comb begin
        n_hdr = r_hdr;
        if (i_cfg_we) begin
            unique case (pcht_pkg::t_cfg_idx'(i_cfg_idx))
                pcht_pkg::CFG_VENDOR:         n_hdr.vendor_id        = i_cfg_data;
                pcht_pkg::CFG_DEVICE:         n_hdr.device_id        = i_cfg_data;
                pcht_pkg::CFG_REVISION_ID:    n_hdr.revision_id      = i_cfg_data[7:0];
                pcht_pkg::CFG_CLASS_PROG_IF:  n_hdr.class_prog_if    = i_cfg_data[7:0];
                pcht_pkg::CFG_CLASS_SUBCLASS: n_hdr.class_subclass   = i_cfg_data[7:0];
                pcht_pkg::CFG_BASE_CLASS:     n_hdr.base_class       = i_cfg_data[7:0];
                pcht_pkg::CFG_SSVID:          n_hdr.subsystem_vendor = i_cfg_data;
                pcht_pkg::CFG_SSDID:          n_hdr.subsystem_device = i_cfg_data;
                default: ;
            endcase
        end
        // writable bytes commit as the word leaves the input register
        if (advance) begin
            if (acc_wr.cmd_lo_we) n_hdr.command_word[7:0]  = acc_wr.cmd_lo;
            if (acc_wr.cmd_hi_we) n_hdr.command_word[15:8] = acc_wr.cmd_hi;
            if (acc_wr.cache_we)  n_hdr.cache_line_size    = acc_wr.cache;
            if (acc_wr.lat_we)    n_hdr.latency_timer      = acc_wr.lat;
            if (acc_wr.int_we)    n_hdr.interrupt_line     = acc_wr.intl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hdr       <= '0;
        end else begin
            r_hdr <= n_hdr;
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.cmd         <= i_req.cmd;
            r_req.byte_offset <= i_req.byte_offset;
            r_req.access_size <= i_req.access_size;
            r_req.write_data  <= i_req.write_data;
        end
        if (advance) begin
            r_rdata <= acc_rdata;
        end
    end

endmodule

`default_nettype wire

>>> hdl/pcht_access.sv
// Combinational access decode: read byte-lane assembly and write byte enables.
// Depends on pcht_pkg.
`default_nettype none

module pcht_access (
    input  pcht_pkg::t_req    i_req,
    input  pcht_pkg::t_hdr    i_hdr,
    output logic [31:0]       o_read_data,
    output pcht_pkg::t_hdr_wr o_wr
);

    function automatic logic [7:0] hdr_byte(pcht_pkg::t_hdr h, logic [12:0] a);
        logic [7:0] b;
        b = '0;
        if (a[12:6] == 7'd0) begin
            unique case (a[5:0])
                pcht_pkg::OFF_VENDOR_LO:  b = h.vendor_id[7:0];
                pcht_pkg::OFF_VENDOR_HI:  b = h.vendor_id[15:8];
                pcht_pkg::OFF_DEVICE_LO:  b = h.device_id[7:0];
                pcht_pkg::OFF_DEVICE_HI:  b = h.device_id[15:8];
                pcht_pkg::OFF_COMMAND_LO: b = h.command_word[7:0];
                pcht_pkg::OFF_COMMAND_HI: b = h.command_word[15:8];
                pcht_pkg::OFF_REVISION:   b = h.revision_id;
                pcht_pkg::OFF_PROG_IF:    b = h.class_prog_if;
                pcht_pkg::OFF_SUBCLASS:   b = h.class_subclass;
                pcht_pkg::OFF_BASE_CLASS: b = h.base_class;
                pcht_pkg::OFF_CACHE_LINE: b = h.cache_line_size;
                pcht_pkg::OFF_LATENCY:    b = h.latency_timer;
                pcht_pkg::OFF_SSVID_LO:   b = h.subsystem_vendor[7:0];
                pcht_pkg::OFF_SSVID_HI:   b = h.subsystem_vendor[15:8];
                pcht_pkg::OFF_SSDID_LO:   b = h.subsystem_device[7:0];
                pcht_pkg::OFF_SSDID_HI:   b = h.subsystem_device[15:8];
                pcht_pkg::OFF_INT_LINE:   b = h.interrupt_line;
                default:                  b = '0;
            endcase
        end
        return b;
    endfunction

    logic        size_ok;
    logic        in_space;
    logic        do_wr;
    logic [12:0] end_addr;
    logic [12:0] lane_addr [4];
    logic [3:0]  lane_on;
    logic [31:0] rd_bytes;

    always_comb begin
        size_ok  = (i_req.access_size == pcht_pkg::SIZE_BYTE) ||
                   (i_req.access_size == pcht_pkg::SIZE_HALF) ||
                   (i_req.access_size == pcht_pkg::SIZE_WORD);
        end_addr = 13'(i_req.byte_offset) + 13'(i_req.access_size);
        in_space = (end_addr <= pcht_pkg::SPACE_LIM);
        do_wr    = i_req.cmd && size_ok && in_space;

        rd_bytes = '0;
        o_wr     = '0;
        for (int i = 0; i < 4; i++) begin
            lane_addr[i] = 13'(i_req.byte_offset) + 13'(i);
            lane_on[i]   = (3'(i) < i_req.access_size);
            if (lane_on[i]) begin
                rd_bytes[8*i +: 8] = hdr_byte(i_hdr, lane_addr[i]);
            end
            // lanes hit distinct addresses, so each target matches one lane at most
            if (do_wr && lane_on[i] && (lane_addr[i][12:6] == 7'd0)) begin
                unique case (lane_addr[i][5:0])
                    pcht_pkg::OFF_COMMAND_LO: begin
                        o_wr.cmd_lo_we = 1'b1;
                        o_wr.cmd_lo    = i_req.write_data[8*i +: 8];
                    end
                    pcht_pkg::OFF_COMMAND_HI: begin
                        o_wr.cmd_hi_we = 1'b1;
                        o_wr.cmd_hi    = i_req.write_data[8*i +: 8];
                    end
                    pcht_pkg::OFF_CACHE_LINE: begin
                        o_wr.cache_we = 1'b1;
                        o_wr.cache    = i_req.write_data[8*i +: 8];
                    end
                    pcht_pkg::OFF_LATENCY: begin
                        o_wr.lat_we = 1'b1;
                        o_wr.lat    = i_req.write_data[8*i +: 8];
                    end
                    pcht_pkg::OFF_INT_LINE: begin
                        o_wr.int_we = 1'b1;
                        o_wr.intl   = i_req.write_data[8*i +: 8];
                    end
                    default: ;
                endcase
            end
        end

        priority if (i_req.cmd) begin
            o_read_data = '0;
        end else if (!size_ok) begin
            o_read_data = '1;
        end else if (!in_space) begin
            // all-ones at the access width
            o_read_data = '0;
            for (int i = 0; i < 4; i++) begin
                if (lane_on[i]) begin
                    o_read_data[8*i +: 8] = 8'hff;
                end
            end
        end else begin
            o_read_data = rd_bytes;
        end
    end

endmodule

`default_nettype wire

>>> hdl/pcht_checker.sv
// Port-level checks for pci_config_header_target, attached with bind.
// Depends only on the top level's ports.
`default_nettype none

module pcht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_rsp_read_data
);

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // backpressure on the input only comes from a stalled output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> (i_rsp_valid && !i_rsp_ready))
        else $error("input stalled while output is free");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> $stable(i_rsp_read_data))
        else $error("response data changed while stalled");

endmodule

bind pci_config_header_target pcht_checker u_pcht_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_read_data (o_rsp.read_data)
);

`default_nettype wire
